// ===== sv/mwm_pkg.sv =====
// Shared codes and default sizes for the maze wall map store.
`timescale 1ns / 1ps

package mwm_pkg;

  // Default grid size.
  localparam int unsigned ROWS_DEF = 16;
  localparam int unsigned COLS_DEF = 16;

  // Operation codes carried by the func field. Codes 5 to 7 act as a read.
  typedef enum logic [2:0] {
    FUNC_READ      = 3'd0,
    FUNC_SET       = 3'd1,
    FUNC_CLEAR     = 3'd2,
    FUNC_APPLY     = 3'd3,
    FUNC_CLEAR_ALL = 3'd4
  } func_e;

  // Wall sides.
  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  // Wall present bit and wall seen bit of the north side; other sides shift up.
  localparam logic [7:0] WALL_BIT = 8'h01;
  localparam logic [7:0] SEEN_BIT = 8'h10;

endpackage

// ===== sv/maze_wall_map_store_unit.sv =====
// Top level of the maze wall map store: operation sequencer around the map memory.
`timescale 1ns / 1ps
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  ----------------------------------------------
//  in       input      in_valid_i / in_ready_o  func_i row_i col_i direction_i wall_data_i
//  out      output     out_valid_o / out_ready_i cell_walls_o neighbour_row_o neighbour_col_o
//
//  One item at a time. Each cell update is a read-modify-write on the single memory
//  port pair: a read reads the cell once, set or clear updates the cell and then its
//  neighbour, apply wall word does so for each side, clear all sweeps every cell,
//  and each then posts its result. After reset a clearing pass zeroes the map;
//  in_ready_o is low during it. A result waiting in the output register does not block
//  the next input transfer; only a second finished result waits for the output to drain.

module maze_wall_map_store_unit #(
  parameter int unsigned ROWS = mwm_pkg::ROWS_DEF,
  parameter int unsigned COLS = mwm_pkg::COLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [3:0] row_i,
  input  logic [3:0] col_i,
  input  logic [1:0] direction_i,
  input  logic [3:0] wall_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cell_walls_o,
  output logic [3:0] neighbour_row_o,
  output logic [3:0] neighbour_col_o
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_CLR  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  // Wrapped neighbour row and column, worked in 7 bits so that a grid of 64 fits.
  function automatic logic [6:0] nb_row(input logic [6:0] r, input logic [1:0] d);
    logic [6:0] res;
    res = r;
    if (d == mwm_pkg::DIR_NORTH) begin
      res = ((r + 7'd1) >= 7'(ROWS)) ? 7'd0 : r + 7'd1;
    end else if (d == mwm_pkg::DIR_SOUTH) begin
      res = (r == 7'd0) ? 7'(ROWS - 1) : r - 7'd1;
    end
    return res;
  endfunction

  function automatic logic [6:0] nb_col(input logic [6:0] c, input logic [1:0] d);
    logic [6:0] res;
    res = c;
    if (d == mwm_pkg::DIR_EAST) begin
      res = ((c + 7'd1) >= 7'(COLS)) ? 7'd0 : c + 7'd1;
    end else if (d == mwm_pkg::DIR_WEST) begin
      res = (c == 7'd0) ? 7'(COLS - 1) : c - 7'd1;
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] cell_idx(input logic [6:0] r, input logic [6:0] c);
    return AW'(32'(r) * COLS + 32'(c));
  endfunction

  state_e        state_q, state_d;
  logic [2:0]    func_q;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [1:0]    dir_q;
  logic [3:0]    data_q;
  logic [2:0]    step_q, last_q;
  logic          clr_item_q;
  logic [AW-1:0] ptr_q;
  logic [7:0]    res_q;
  logic [3:0]    nbr_q, nbc_q;
  logic          out_valid_q;
  logic [7:0]    out_cell_q;
  logic [3:0]    out_nbr_q, out_nbc_q;

  // Input side: saturated cell and the neighbour reported for this item.
  logic [6:0] row_sat, col_sat, in_nbr, in_nbc;
  logic       in_xfer;

  always_comb begin
    row_sat = (7'(row_i) >= 7'(ROWS)) ? 7'(ROWS - 1) : 7'(row_i);
    col_sat = (7'(col_i) >= 7'(COLS)) ? 7'(COLS - 1) : 7'(col_i);
    in_nbr  = nb_row(row_sat, direction_i);
    in_nbc  = nb_col(col_sat, direction_i);
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Current update step. Odd steps touch the neighbour on the opposite side.
  logic          is_apply, is_nb, modify, present;
  logic [1:0]    step_dir, side;
  logic [6:0]    step_nr, step_nc;
  logic [AW-1:0] step_addr;
  logic [7:0]    wmask, new_byte, rdata;

  always_comb begin
    is_apply  = (func_q == mwm_pkg::FUNC_APPLY);
    modify    = (func_q == mwm_pkg::FUNC_SET) || (func_q == mwm_pkg::FUNC_CLEAR) || is_apply;
    step_dir  = is_apply ? step_q[2:1] : dir_q;
    is_nb     = step_q[0];
    side      = is_nb ? step_dir + 2'd2 : step_dir;
    present   = is_apply ? data_q[step_dir] : (func_q == mwm_pkg::FUNC_SET);
    step_nr   = nb_row(7'(r_q), step_dir);
    step_nc   = nb_col(7'(c_q), step_dir);
    step_addr = is_nb ? cell_idx(step_nr, step_nc) : cell_idx(7'(r_q), 7'(c_q));
    wmask     = mwm_pkg::WALL_BIT << side;
    new_byte  = rdata;
    if (modify) begin
      new_byte = (rdata & ~wmask) | (present ? wmask : 8'h00) | (mwm_pkg::SEEN_BIT << side);
    end
  end

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign ram_we    = (state_q == S_CLR) || ((state_q == S_WR) && modify);
  assign ram_waddr = (state_q == S_CLR) ? ptr_q : step_addr;
  assign ram_wdata = (state_q == S_CLR) ? 8'h00 : new_byte;
  assign ram_re    = (state_q == S_RD);

  mwm_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(step_addr),
    .rdata_o(rdata)
  );

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (func_i == mwm_pkg::FUNC_CLEAR_ALL) ? S_CLR : S_RD;
        end
      end
      S_RD: state_d = S_WR;
      S_WR: state_d = (step_q == last_q) ? S_DONE : S_RD;
      S_CLR: begin
        if (ptr_q == AW'(DEPTH - 1)) begin
          state_d = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state; the reset value starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      step_q      <= 3'd0;
      ptr_q       <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        step_q     <= 3'd0;
        ptr_q      <= '0;
        clr_item_q <= (func_i == mwm_pkg::FUNC_CLEAR_ALL);
      end
      if ((state_q == S_WR) && (step_q != last_q)) begin
        step_q <= step_q + 3'd1;
      end
      if (state_q == S_CLR) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_i;
      r_q    <= row_sat[RW-1:0];
      c_q    <= col_sat[CW-1:0];
      dir_q  <= direction_i;
      data_q <= wall_data_i;
      nbr_q  <= in_nbr[3:0];
      nbc_q  <= in_nbc[3:0];
      case (func_i) inside
        mwm_pkg::FUNC_SET, mwm_pkg::FUNC_CLEAR: last_q <= 3'd1;
        mwm_pkg::FUNC_APPLY:                    last_q <= 3'd7;
        default:                                last_q <= 3'd0;
      endcase
    end
    // The addressed cell is never its own neighbour, so its last write is final.
    if ((state_q == S_WR) && !is_nb) begin
      res_q <= new_byte;
    end
    if ((state_q == S_CLR) && clr_item_q) begin
      res_q <= 8'h00;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_cell_q <= res_q;
      out_nbr_q  <= nbr_q;
      out_nbc_q  <= nbc_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_walls_o    = out_cell_q;
  assign neighbour_row_o = out_nbr_q;
  assign neighbour_col_o = out_nbc_q;

endmodule

// ===== sv/mwm_ram.sv =====
// Simple dual-port wall map memory with a registered read port.
`timescale 1ns / 1ps

module mwm_ram #(
  parameter int unsigned DEPTH = mwm_pkg::ROWS_DEF * mwm_pkg::COLS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mwm_chk.sv =====
// Port-level assertions for the maze wall map store, bound to the top level.
`timescale 1ns / 1ps

module mwm_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] cell_walls_o,
  input logic [3:0] neighbour_row_o,
  input logic [3:0] neighbour_col_o
);

  // A result waiting for a transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cell_walls_o)
      && $stable(neighbour_row_o) && $stable(neighbour_col_o)))
    else $error("output payload changed while stalled");

  // Items are worked one at a time: after an input transfer the port closes.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again while an item is in work");

  // A new result only appears while the input side is closed for its item.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result posted with no item in work");

  // The map is swept after reset before any item is taken.
  a_reset_sweep: assert property (@(posedge clk_i)
    !rst_ni |=> (!in_ready_o && !out_valid_o))
    else $error("input open or result valid right after reset");

endmodule

bind maze_wall_map_store_unit mwm_chk u_mwm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .cell_walls_o   (cell_walls_o),
  .neighbour_row_o(neighbour_row_o),
  .neighbour_col_o(neighbour_col_o)
);

// ===== tb/maze_wall_map_store_unit_tb.sv =====
// Self-checking testbench for the maze wall map store: a shadow wall map predicts each reply.
`timescale 1ns / 1ps

module maze_wall_map_store_unit_tb;

  localparam int unsigned ROWS = mwm_pkg::ROWS_DEF;
  localparam int unsigned COLS = mwm_pkg::COLS_DEF;
  localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] walls;
    logic [3:0] nrow;
    logic [3:0] ncol;
  } map_reply_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] func_i = mwm_pkg::FUNC_READ;
  logic [3:0] row_i = '0;
  logic [3:0] col_i = '0;
  logic [1:0] direction_i = mwm_pkg::DIR_NORTH;
  logic [3:0] wall_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] cell_walls_o;
  logic [3:0] neighbour_row_o;
  logic [3:0] neighbour_col_o;

  logic [7:0] wall_shadow [ROWS*COLS];
  map_reply_t pending_replies [$];
  int         mismatch_count = 0;
  int         burst_left = 0;
  logic       hold_request = 1'b0;
  int         hold_left = 0;
  int         ready_mode = 0;
  int         mode_left = 0;
  logic [1:0] ready_phase = '0;

  maze_wall_map_store_unit #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .direction_i    (direction_i),
    .wall_data_i    (wall_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_walls_o   (cell_walls_o),
    .neighbour_row_o(neighbour_row_o),
    .neighbour_col_o(neighbour_col_o)
  );

  always #10 clk_i = ~clk_i;

  // Neighbours wrap around in both axes, as on a torus.
  function automatic void find_neighbour(input int unsigned r, input int unsigned c,
                                         input logic [1:0] d,
                                         output int unsigned nr, output int unsigned nc);
    nr = r;
    nc = c;
    case (d)
      mwm_pkg::DIR_NORTH: nr = (r + 1 >= ROWS) ? 0 : r + 1;
      mwm_pkg::DIR_EAST:  nc = (c + 1 >= COLS) ? 0 : c + 1;
      mwm_pkg::DIR_SOUTH: nr = (r == 0) ? ROWS - 1 : r - 1;
      default:            nc = (c == 0) ? COLS - 1 : c - 1;
    endcase
  endfunction

  function automatic void mark_wall(input int unsigned r, input int unsigned c,
                                    input logic [1:0] d, input logic present);
    int unsigned idx;
    logic [7:0]  v;
    idx = r * COLS + c;
    if (idx >= ROWS * COLS) return;
    v = wall_shadow[idx];
    if (present) v = v | (mwm_pkg::WALL_BIT << d);
    else v = v & ~(mwm_pkg::WALL_BIT << d);
    wall_shadow[idx] = v | (mwm_pkg::SEEN_BIT << d);
  endfunction

  function automatic void change_wall(input int unsigned r, input int unsigned c,
                                      input logic [1:0] d, input logic present);
    int unsigned nr;
    int unsigned nc;
    logic [1:0]  opp;
    opp = d + 2'd2;
    mark_wall(r, c, d, present);
    find_neighbour(r, c, d, nr, nc);
    mark_wall(nr, nc, opp, present);
  endfunction

  function automatic map_reply_t apply_map_op(input logic [2:0] fn, input logic [3:0] row,
                                              input logic [3:0] col, input logic [1:0] d,
                                              input logic [3:0] wd);
    int unsigned r;
    int unsigned c;
    int unsigned nr;
    int unsigned nc;
    map_reply_t  rep;
    r = row;
    c = col;
    if (r >= ROWS) r = ROWS - 1;
    if (c >= COLS) c = COLS - 1;
    case (fn)
      mwm_pkg::FUNC_SET:   change_wall(r, c, d, 1'b1);
      mwm_pkg::FUNC_CLEAR: change_wall(r, c, d, 1'b0);
      mwm_pkg::FUNC_APPLY: begin
        // Sides go north, east, south, west; a later side wins on a shared cell.
        for (int k = 0; k < 4; k++) change_wall(r, c, 2'(k), wd[k]);
      end
      mwm_pkg::FUNC_CLEAR_ALL: begin
        foreach (wall_shadow[i]) wall_shadow[i] = '0;
      end
      default: ;
    endcase
    find_neighbour(r, c, d, nr, nc);
    rep.walls = wall_shadow[r * COLS + c];
    rep.nrow  = 4'(nr);
    rep.ncol  = 4'(nc);
    return rep;
  endfunction

  // Signals are stable at the falling edge, so a transfer seen here completes at the next
  // rising edge.
  always @(negedge clk_i) begin
    map_reply_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        pending_replies.push_back(apply_map_op(func_i, row_i, col_i, direction_i,
                                               wall_data_i));
      if (out_valid_o && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result, actual walls %02h row %0d col %0d", $time,
                   cell_walls_o, neighbour_row_o, neighbour_col_o);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          if (cell_walls_o !== want.walls) begin
            $display("%0t: cell_walls mismatch, expected %02h, actual %02h", $time,
                     want.walls, cell_walls_o);
            mismatch_count++;
          end
          if (neighbour_row_o !== want.nrow) begin
            $display("%0t: neighbour_row mismatch, expected %0d, actual %0d", $time,
                     want.nrow, neighbour_row_o);
            mismatch_count++;
          end
          if (neighbour_col_o !== want.ncol) begin
            $display("%0t: neighbour_col mismatch, expected %0d, actual %0d", $time,
                     want.ncol, neighbour_col_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // The receiver alternates between always ready, random stalls and a fixed stall pattern.
  // A requested hold-off keeps it stalled long enough for the block to back up.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    ready_phase <= ready_phase + 2'd1;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= (ready_phase != 2'd3);
      endcase
    end
  end

  // Called right after a rising edge; returns right after the edge that took the transfer.
  task automatic send_item(input logic [2:0] fn, input logic [3:0] row, input logic [3:0] col,
                           input mwm_pkg::dir_e d, input logic [3:0] wd);
    int   gap;
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    row_i       <= row;
    col_i       <= col;
    direction_i <= d;
    wall_data_i <= wd;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic wait_replies_done();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_read();
    send_item(mwm_pkg::FUNC_READ, 4'd0, 4'd0, mwm_pkg::DIR_NORTH, 4'h0);
    send_item(mwm_pkg::FUNC_READ, 4'd15, 4'd15, mwm_pkg::DIR_WEST, 4'hF);
  endtask

  task automatic test_edge_wrap();
    send_item(mwm_pkg::FUNC_SET, 4'd15, 4'd3, mwm_pkg::DIR_NORTH, 4'h0);
    send_item(mwm_pkg::FUNC_SET, 4'd7, 4'd15, mwm_pkg::DIR_EAST, 4'h0);
    send_item(mwm_pkg::FUNC_SET, 4'd0, 4'd9, mwm_pkg::DIR_SOUTH, 4'h0);
    send_item(mwm_pkg::FUNC_SET, 4'd4, 4'd0, mwm_pkg::DIR_WEST, 4'h0);
    send_item(mwm_pkg::FUNC_CLEAR, 4'd15, 4'd3, mwm_pkg::DIR_NORTH, 4'h0);
    send_item(mwm_pkg::FUNC_READ, 4'd0, 4'd3, mwm_pkg::DIR_SOUTH, 4'h0);
  endtask

  task automatic test_apply_words();
    send_item(mwm_pkg::FUNC_APPLY, 4'd0, 4'd0, mwm_pkg::DIR_NORTH, 4'hF);
    send_item(mwm_pkg::FUNC_READ, 4'd15, 4'd0, mwm_pkg::DIR_NORTH, 4'h0);
    send_item(mwm_pkg::FUNC_APPLY, 4'd0, 4'd0, mwm_pkg::DIR_EAST, 4'h0);
    send_item(mwm_pkg::FUNC_APPLY, 4'd15, 4'd15, mwm_pkg::DIR_SOUTH, 4'h5);
    send_item(mwm_pkg::FUNC_APPLY, 4'd15, 4'd15, mwm_pkg::DIR_WEST, 4'hA);
    send_item(mwm_pkg::FUNC_READ, 4'd15, 4'd0, mwm_pkg::DIR_WEST, 4'h0);
  endtask

  task automatic test_unused_codes();
    for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
      send_item(3'(f), 4'd15, 4'd15, mwm_pkg::DIR_EAST, 4'hF);
  endtask

  task automatic test_clear_all();
    send_item(mwm_pkg::FUNC_CLEAR_ALL, 4'd15, 4'd15, mwm_pkg::DIR_SOUTH, 4'hF);
    send_item(mwm_pkg::FUNC_READ, 4'd0, 4'd0, mwm_pkg::DIR_WEST, 4'h0);
  endtask

  task automatic send_random_item();
    int         pick;
    logic [2:0] fn;
    logic [3:0] row;
    logic [3:0] col;
    pick = $urandom_range(0, 199);
    if (pick < 50) fn = mwm_pkg::FUNC_READ;
    else if (pick < 100) fn = mwm_pkg::FUNC_SET;
    else if (pick < 140) fn = mwm_pkg::FUNC_CLEAR;
    else if (pick < 190) fn = mwm_pkg::FUNC_APPLY;
    else if (pick < 193) fn = mwm_pkg::FUNC_CLEAR_ALL;
    else fn = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
    // Much of the traffic stays around the corner where both axes wrap, so updates
    // overlap and read back each other's neighbours.
    if ($urandom_range(0, 9) < 4) begin
      row = 4'($urandom_range(0, 2) + ROWS - 1);
      col = 4'($urandom_range(0, 2) + COLS - 1);
    end else begin
      row = 4'($urandom_range(0, 15));
      col = 4'($urandom_range(0, 15));
    end
    send_item(fn, row, col, mwm_pkg::dir_e'($urandom_range(0, 3)),
              4'($urandom_range(0, 15)));
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (12) send_random_item();
  endtask

  task automatic test_drain_pause();
    repeat (6) send_random_item();
    wait_replies_done();
    repeat (6) send_random_item();
  endtask

  task automatic test_random();
    repeat (RANDOM_ITEMS) send_random_item();
  endtask

  initial begin
    int wait_cnt;
    foreach (wall_shadow[i]) wall_shadow[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_read();
    test_edge_wrap();
    test_apply_words();
    test_unused_codes();
    test_clear_all();
    test_backpressure();
    test_drain_pause();
    test_random();
    in_valid_i <= 1'b0;
    wait_cnt = 0;
    while (pending_replies.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_replies.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
